[sv/lwmqd_pkg.sv]
// ----------------------------------------------------------------------------
// Least-work queue dispatcher package
// Sizes, field widths, status codes and the slot address helper.
// ----------------------------------------------------------------------------
`default_nettype none

package lwmqd_pkg;

	localparam int NUM_QUEUES  = 3;
	localparam int QUEUE_DEPTH = 64;
	localparam int SLOT_COUNT  = NUM_QUEUES * QUEUE_DEPTH;

	localparam int WORK_W   = 10;
	localparam int ID_W     = 16;
	localparam int QSEL_W   = 2;
	localparam int STATUS_W = 2;

	localparam int PTR_W   = $clog2(QUEUE_DEPTH);
	localparam int OCC_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W  = $clog2(SLOT_COUNT);
	localparam int TOTAL_W = $clog2(QUEUE_DEPTH * ((1 << WORK_W) - 1) + 1);
	localparam int SLOT_W  = ID_W + WORK_W;

	// stream packing
	localparam int IN_DATA_W  = 16;  // work_amount, queue_select, pad
	localparam int IN_USER_W  = 1;   // action
	localparam int OUT_DATA_W = 32;  // queue_index, job_id, job_work, pad
	localparam int OUT_USER_W = 2;   // status

	typedef logic [PTR_W-1:0]   ptr_t;
	typedef logic [OCC_W-1:0]   occ_t;
	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [TOTAL_W-1:0] total_t;
	typedef logic [WORK_W-1:0]  work_t;
	typedef logic [ID_W-1:0]    id_t;
	typedef logic [QSEL_W-1:0]  qsel_t;

	typedef enum logic [0:0] {
		ACT_ADD   = 1'b0,
		ACT_SERVE = 1'b1
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_BADQ  = 2'd3
	} status_t;

	localparam id_t ID_FIRST = id_t'(1);
	localparam id_t ID_LAST  = '1;

	function automatic addr_t slot_addr(qsel_t q, ptr_t p);
		return addr_t'(addr_t'(q) * addr_t'(QUEUE_DEPTH)) + addr_t'(p);
	endfunction

	function automatic ptr_t ptr_next(ptr_t p);
		return (p == ptr_t'(QUEUE_DEPTH - 1)) ? '0 : p + ptr_t'(1);
	endfunction

endpackage

`default_nettype wire

[sv/least_work_multi_queue_dispatch.sv]
// ----------------------------------------------------------------------------
// Least-work multi-queue dispatcher
// Circular job queues; adds go to the queue with the least queued work.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_* stream: s_tuser is the action (add or serve),
//   s_tdata carries work_amount and queue_select. Every request gives exactly
//   one result on the m_* stream: m_tuser is the status, m_tdata carries
//   queue_index, job_id and job_work.
//   A request passes the input register and then the result register. One
//   request per cycle is sustained while m_tready is high: the input register
//   feeds the queue decision, and the result register together with the
//   registered read of the slot RAM holds the answer. The slot RAM is touched
//   at most once per request (write on a stored add, read on a good serve).
//   A serve takes its work amount off the queue total in the next cycle, when
//   the slot data arrives; the least-work compare sees that pending amount
//   already subtracted.
//   Reset empties every queue and sets the next job id to 1; slot contents
//   are not cleared and need no clearing pass.
//   When m_tready is low the result holds and the input register stalls;
//   s_tready stays high while the input register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module least_work_multi_queue_dispatch (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// [9:0] work_amount, [11:10] queue_select, [15:12] zero
	input  wire logic [lwmqd_pkg::IN_DATA_W-1:0]  s_tdata,
	// [0] action
	input  wire logic [lwmqd_pkg::IN_USER_W-1:0]  s_tuser,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// [1:0] queue_index, [17:2] job_id, [27:18] job_work, [31:28] zero
	output logic      [lwmqd_pkg::OUT_DATA_W-1:0] m_tdata,
	// [1:0] status
	output logic      [lwmqd_pkg::OUT_USER_W-1:0] m_tuser
);

	import lwmqd_pkg::*;

	// input register
	logic    valid_s1;
	action_t action_s1;
	work_t   work_s1;
	qsel_t   sel_s1;

	// result register
	logic    valid_s2;
	status_t status_s2;
	qsel_t   qidx_s2;
	id_t     id_s2;
	work_t   work_s2;
	logic    from_ram_s2;

	// queue state
	ptr_t   head_q  [NUM_QUEUES];
	ptr_t   tail_q  [NUM_QUEUES];
	occ_t   occ_q   [NUM_QUEUES];
	total_t total_q [NUM_QUEUES];
	id_t    next_id_q;
	logic   sub_pend_q;

	logic [SLOT_W-1:0] ram_rdata;
	work_t             ram_work;
	id_t               ram_id;

	logic    advance;
	logic    take_s1;
	total_t  eff_total [NUM_QUEUES];
	qsel_t   pick;
	total_t  pick_val;
	logic    is_add;
	logic    sel_ok;
	qsel_t   opq;
	occ_t    occ_op;
	logic    full;
	logic    empty;
	logic    do_push;
	logic    do_pop;
	status_t status_d;
	qsel_t   qidx_d;
	id_t     id_d;
	work_t   work_d;
	id_t     job_id_out;
	work_t   job_work_out;

	assign ram_id   = ram_rdata[SLOT_W-1:WORK_W];
	assign ram_work = ram_rdata[WORK_W-1:0];

	assign advance  = !valid_s2 || m_tready;
	assign take_s1  = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	// totals with the in-flight serve amount taken off, then least-work pick
	always_comb begin
		for (int i = 0; i < NUM_QUEUES; i++) begin
			eff_total[i] = total_q[i];
			if (sub_pend_q && qidx_s2 == qsel_t'(i)) begin
				eff_total[i] = total_q[i] - total_t'(ram_work);
			end
		end
		pick     = '0;
		pick_val = eff_total[0];
		for (int i = 1; i < NUM_QUEUES; i++) begin
			if (eff_total[i] < pick_val) begin
				pick     = qsel_t'(i);
				pick_val = eff_total[i];
			end
		end
	end

	assign is_add = (action_s1 == ACT_ADD);
	assign sel_ok = {1'b0, sel_s1} < (QSEL_W + 1)'(NUM_QUEUES);
	assign opq    = is_add ? pick : sel_s1;
	assign occ_op = occ_q[opq];
	assign full   = (occ_op == occ_t'(QUEUE_DEPTH));
	assign empty  = (occ_op == '0);

	assign do_push = take_s1 && is_add && !full;
	assign do_pop  = take_s1 && !is_add && sel_ok && !empty;

	always_comb begin
		status_d = ST_OK;
		qidx_d   = opq;
		id_d     = '0;
		work_d   = '0;
		if (is_add) begin
			status_d = full ? ST_FULL : ST_OK;
			id_d     = next_id_q;
			work_d   = work_s1;
		end else if (!sel_ok) begin
			status_d = ST_BADQ;
			qidx_d   = '0;
		end else if (empty) begin
			status_d = ST_EMPTY;
		end
	end

	lwmqd_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(SLOT_COUNT)
	) u_slots (
		.clk  (clk),
		.we   (do_push),
		.waddr(slot_addr(opq, tail_q[opq])),
		.wdata({next_id_q, work_s1}),
		.re   (do_pop),
		.raddr(slot_addr(opq, head_q[opq])),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			sub_pend_q <= 1'b0;
			next_id_q  <= ID_FIRST;
			for (int i = 0; i < NUM_QUEUES; i++) begin
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
				occ_q[i]   <= '0;
				total_q[i] <= '0;
			end
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
			sub_pend_q <= do_pop;
			if (take_s1 && is_add) begin
				next_id_q <= (next_id_q == ID_LAST) ? ID_FIRST : next_id_q + id_t'(1);
			end
			for (int i = 0; i < NUM_QUEUES; i++) begin
				if (do_push && opq == qsel_t'(i)) begin
					total_q[i] <= eff_total[i] + total_t'(work_s1);
				end else begin
					total_q[i] <= eff_total[i];
				end
				if (opq == qsel_t'(i)) begin
					if (do_push) begin
						tail_q[i] <= ptr_next(tail_q[i]);
						occ_q[i]  <= occ_q[i] + occ_t'(1);
					end
					if (do_pop) begin
						head_q[i] <= ptr_next(head_q[i]);
						occ_q[i]  <= occ_q[i] - occ_t'(1);
					end
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			action_s1 <= action_t'(s_tuser[0]);
			work_s1   <= s_tdata[WORK_W-1:0];
			sel_s1    <= s_tdata[WORK_W +: QSEL_W];
		end
		if (take_s1) begin
			status_s2   <= status_d;
			qidx_s2     <= qidx_d;
			id_s2       <= id_d;
			work_s2     <= work_d;
			from_ram_s2 <= do_pop;
		end
	end

	assign job_id_out   = from_ram_s2 ? ram_id : id_s2;
	assign job_work_out = from_ram_s2 ? ram_work : work_s2;

	assign m_tvalid = valid_s2;
	assign m_tuser  = status_s2;
	assign m_tdata  = OUT_DATA_W'({job_work_out, job_id_out, qidx_s2});

	// ------------------------------------------------------------------------
	// assertions

	// a pending total correction always belongs to the served result on hand
	a_sub_pending: assert property (@(posedge clk) disable iff (!arst_n)
		sub_pend_q |-> (valid_s2 && from_ram_s2 && status_s2 == ST_OK))
		else $error("pending work correction without a served result");

	// id zero is never handed out
	a_id_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		next_id_q != '0)
		else $error("next job id is zero");

	// a stalled result keeps its slot data: no RAM read while the output waits
	a_ram_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !m_tready) |-> !do_pop)
		else $error("slot read while result is stalled");

	for (genvar g = 0; g < NUM_QUEUES; g++) begin : g_occ_chk
		a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
			occ_q[g] <= occ_t'(QUEUE_DEPTH))
			else $error("queue occupancy above depth");
	end

endmodule

`default_nettype wire

[sv/lwmqd_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lwmqd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[dv/tb_least_work_multi_queue_dispatch.sv]
// ----------------------------------------------------------------------------
// Testbench for the least-work multi-queue dispatcher
// Drives add and serve requests on the input stream with bursty valid and a
// stalling receiver. A scoreboard model of the job queues predicts every
// result. Runs a short directed table, then an add-heavy run that nearly
// fills the queues, then mixed random traffic with fill, drain and bad-index
// phases.
// ----------------------------------------------------------------------------
module tb_least_work_multi_queue_dispatch;
	import lwmqd_pkg::*;

	localparam int RAND_ITEMS    = 1450;
	localparam int HOLD_CYCLES   = 400;
	localparam int WDOG_LIMIT    = 4000;
	localparam int DRAIN_CYCLES  = 10;
	localparam id_t ID_SWEEP_END = id_t'(230);

	typedef struct packed {
		id_t   id;
		work_t work;
	} job_t;

	typedef struct packed {
		status_t status;
		qsel_t   qidx;
		id_t     job_id;
		work_t   job_work;
	} dispatch_res_t;

	typedef struct packed {
		action_t       act;
		work_t         work;
		qsel_t         qsel;
		logic          typed;
		dispatch_res_t res;
	} dir_row_t;

	typedef enum int {MIX_MIXED, MIX_FILL, MIX_DRAIN, MIX_NOISE} mix_t;
	typedef enum int {RX_OPEN, RX_COIN, RX_CADENCE, RX_SPARSE} rx_mode_t;

	localparam dispatch_res_t NO_RES = '{ST_OK, 2'd0, 16'd0, 10'd0};
	localparam int DIR_N = 23;

	// typed rows hold what the block must give for that request
	localparam dir_row_t DIR_TBL [DIR_N] = '{
		'{ACT_SERVE, 10'd0,    2'd0, 1'b1, '{ST_EMPTY, 2'd0, 16'd0, 10'd0}},
		'{ACT_SERVE, 10'd1023, 2'd1, 1'b1, '{ST_EMPTY, 2'd1, 16'd0, 10'd0}},
		'{ACT_SERVE, 10'd512,  2'd2, 1'b1, '{ST_EMPTY, 2'd2, 16'd0, 10'd0}},
		'{ACT_SERVE, 10'd1023, 2'd3, 1'b1, '{ST_BADQ,  2'd0, 16'd0, 10'd0}},
		'{ACT_ADD,   10'd0,    2'd3, 1'b1, '{ST_OK,    2'd0, 16'd1, 10'd0}},
		'{ACT_ADD,   10'd1023, 2'd0, 1'b1, '{ST_OK,    2'd0, 16'd2, 10'd1023}},
		'{ACT_ADD,   10'd1023, 2'd2, 1'b0, NO_RES},
		'{ACT_ADD,   10'd512,  2'd1, 1'b0, NO_RES},
		'{ACT_ADD,   10'd1,    2'd0, 1'b0, NO_RES},
		'{ACT_ADD,   10'd1,    2'd0, 1'b0, NO_RES},
		'{ACT_ADD,   10'd1023, 2'd0, 1'b0, NO_RES},
		'{ACT_SERVE, 10'd0,    2'd0, 1'b0, NO_RES},
		'{ACT_SERVE, 10'd0,    2'd0, 1'b0, NO_RES},
		'{ACT_SERVE, 10'd1023, 2'd0, 1'b0, NO_RES},
		'{ACT_ADD,   10'd341,  2'd0, 1'b0, NO_RES},
		'{ACT_SERVE, 10'd0,    2'd3, 1'b1, '{ST_BADQ,  2'd0, 16'd0, 10'd0}},
		'{ACT_SERVE, 10'd682,  2'd1, 1'b0, NO_RES},
		'{ACT_SERVE, 10'd0,    2'd2, 1'b0, NO_RES},
		'{ACT_SERVE, 10'd0,    2'd2, 1'b0, NO_RES},
		'{ACT_SERVE, 10'd0,    2'd2, 1'b0, NO_RES},
		'{ACT_SERVE, 10'd0,    2'd2, 1'b0, NO_RES},
		'{ACT_SERVE, 10'd0,    2'd2, 1'b0, NO_RES},
		'{ACT_ADD,   10'd1023, 2'd1, 1'b0, NO_RES}
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [IN_USER_W-1:0]  s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [OUT_USER_W-1:0] m_tuser;

	// scoreboard copy of the queues
	job_t          job_fifo [NUM_QUEUES][$];
	total_t        work_total [NUM_QUEUES];
	id_t           id_next = ID_FIRST;
	int            id_wraps = 0;
	dispatch_res_t result_q [$];

	int burst_left = 0;
	bit hold_pending = 1'b0;
	int err_count = 0;
	int status_seen [4] = '{0, 0, 0, 0};
	int idle_cycles = 0;

	always #1 clk = ~clk;

	least_work_multi_queue_dispatch u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	function automatic dispatch_res_t predict_dispatch(action_t act, work_t work, qsel_t qsel);
		dispatch_res_t r;
		qsel_t         best;
		job_t          j;
		r = NO_RES;
		if (act == ACT_ADD) begin
			best = '0;
			for (int i = 1; i < NUM_QUEUES; i++)
				if (work_total[i] < work_total[best])
					best = qsel_t'(i);
			r.qidx     = best;
			r.job_id   = id_next;
			r.job_work = work;
			// id 0 is skipped on wrap
			if (id_next == ID_LAST) begin
				id_next = ID_FIRST;
				id_wraps++;
			end else begin
				id_next = id_next + id_t'(1);
			end
			if (job_fifo[best].size() >= QUEUE_DEPTH) begin
				r.status = ST_FULL;
			end else begin
				job_fifo[best].push_back('{r.job_id, work});
				work_total[best] = work_total[best] + total_t'(work);
			end
		end else if (int'(qsel) >= NUM_QUEUES) begin
			r.status = ST_BADQ;
		end else if (job_fifo[qsel].size() == 0) begin
			r.status = ST_EMPTY;
			r.qidx   = qsel;
		end else begin
			j = job_fifo[qsel].pop_front();
			work_total[qsel] = work_total[qsel] - total_t'(j.work);
			r.qidx     = qsel;
			r.job_id   = j.id;
			r.job_work = j.work;
		end
		return r;
	endfunction

	function automatic work_t rand_work();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return work_t'($urandom_range(1, 15));
			default: return work_t'($urandom);
		endcase
	endfunction

	// one request through the handshake; gaps fall between bursts
	task automatic send_req(input action_t act, input work_t work, input qsel_t qsel,
			input logic typed, input dispatch_res_t typed_res);
		dispatch_res_t r;
		int            gap;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				s_tdata  <= IN_DATA_W'($urandom);
				s_tuser  <= IN_USER_W'($urandom);
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {4'b0, qsel, work};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		r = predict_dispatch(act, work, qsel);
		result_q.push_back(typed ? typed_res : r);
		burst_left--;
	endtask

	// result checking and receiver stalls
	always @(posedge clk) begin : rx_side
		dispatch_res_t   want;
		dispatch_res_t   got;
		logic [3:0]      pad;
		static int       hold_left = 0;
		static int       mode_left = 0;
		static int       tick = 0;
		static rx_mode_t rx_mode = RX_OPEN;
		if (m_tvalid && m_tready) begin
			got = '{status_t'(m_tuser), m_tdata[1:0], m_tdata[17:2], m_tdata[27:18]};
			pad = m_tdata[31:28];
			if (result_q.size() == 0) begin
				err_count++;
				if (err_count <= 10)
					$display("unexpected result: status %0d queue %0d id %0d work %0d",
						got.status, got.qidx, got.job_id, got.job_work);
			end else begin
				want = result_q.pop_front();
				status_seen[want.status]++;
				if (got.status != want.status || got.qidx != want.qidx ||
						got.job_id != want.job_id || got.job_work != want.job_work ||
						pad != 4'd0) begin
					err_count++;
					if (err_count <= 10)
						$display({"mismatch: exp status %0d queue %0d id %0d work %0d, ",
							"got status %0d queue %0d id %0d work %0d pad %h"},
							want.status, want.qidx, want.job_id, want.job_work,
							got.status, got.qidx, got.job_id, got.job_work, pad);
				end
			end
		end

		if (hold_pending) begin
			hold_left    = HOLD_CYCLES;
			hold_pending = 1'b0;
		end
		tick++;
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			if (mode_left <= 0) begin
				rx_mode   = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 300);
			end
			mode_left--;
			case (rx_mode)
				RX_OPEN:    m_tready <= 1'b1;
				RX_COIN:    m_tready <= 1'($urandom_range(0, 1));
				RX_CADENCE: m_tready <= (tick % 3 == 0);
				default:    m_tready <= ($urandom_range(0, 4) == 0);
			endcase
		end
	end

	// nothing moving on either side for too long means a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WDOG_LIMIT) begin
				$display("watchdog: no request or result for %0d cycles", WDOG_LIMIT);
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin : stim
		action_t act;
		work_t   work;
		qsel_t   qsel;
		mix_t    mix;
		int      seg_left;
		int      sweep_n;
		int      pct;
		for (int q = 0; q < NUM_QUEUES; q++)
			work_total[q] = '0;
		mix      = MIX_MIXED;
		seg_left = 0;
		sweep_n  = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_N; i++)
			send_req(DIR_TBL[i].act, DIR_TBL[i].work, DIR_TBL[i].qsel,
				DIR_TBL[i].typed, DIR_TBL[i].res);

		// add-heavy run; queues end up mostly full
		while (id_next < ID_SWEEP_END) begin
			act = ($urandom_range(0, 99) < 85) ? ACT_ADD : ACT_SERVE;
			qsel = qsel_t'($urandom_range(0, 3));
			send_req(act, rand_work(), qsel, 1'b0, NO_RES);
			sweep_n++;
		end

		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (seg_left <= 0) begin
				mix      = mix_t'($urandom_range(0, 3));
				seg_left = (mix == MIX_FILL) ? $urandom_range(60, 250)
					: $urandom_range(20, 120);
			end
			seg_left--;
			case (mix)
				MIX_FILL:  pct = 90;
				MIX_DRAIN: pct = 15;
				default:   pct = 50;
			endcase
			act  = ($urandom_range(0, 99) < pct) ? ACT_ADD : ACT_SERVE;
			work = rand_work();
			if (act == ACT_ADD || mix == MIX_NOISE)
				qsel = qsel_t'($urandom_range(0, 3));
			else
				qsel = ($urandom_range(0, 9) == 0) ? qsel_t'(3) : qsel_t'($urandom_range(0, 2));
			// long receiver hold-off while requests keep coming
			if (n == RAND_ITEMS / 3) begin
				hold_pending = 1'b1;
				burst_left   = 600;
			end
			send_req(act, work, qsel, 1'b0, NO_RES);
		end
		s_tvalid <= 1'b0;

		while (result_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("ran %0d directed, %0d sweep and %0d random requests; id wrapped %0d time(s)",
			DIR_N, sweep_n, RAND_ITEMS, id_wraps);
		$display("results: ok %0d, full %0d, empty %0d, bad index %0d; %0d mismatch(es)",
			status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
			status_seen[ST_BADQ], err_count);
		if (err_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
